// ----- src/ctfi_pkg.sv -----
// ctfi_pkg: shared constants for the chart text foreground isolator
// no dependencies; imported by the top level
`default_nettype none
package ctfi_pkg;
  localparam int PIX_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STRIDE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEXT_SAT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_CONTRAST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRONG_CONTRAST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_SAT     = 3'd4;

  localparam logic [7:0] BG_RESET        = 8'd255;
  localparam logic [7:0] MID_LEVEL       = 8'd128;
  localparam logic [7:0] TEXT_DARK_MAX   = 8'd96;
  localparam logic [7:0] TEXT_BRIGHT_MIN = 8'd160;
  localparam logic [7:0] MIN_CONTRAST    = 8'd6;
  localparam logic [7:0] MODERATE_CAP    = 8'd96;
  localparam logic [7:0] LEVEL_MAX       = 8'd255;

  localparam logic [2:0] DIV_STEPS = 3'd7;
endpackage
`default_nettype wire

// ----- src/chart_text_foreground_isolator.sv -----
// chart_text_foreground_isolator: luminance histogram background finder and
// per-pixel text strength classifier; uses ctfi_pkg and ctfi_ram
//
//   channel  dir  tdata                                   tuser      tlast
//   in_      in   red, green, blue                        req_type   last_pixel
//   out_     out  saturation, strength, chroma,           kind       last
//                 background_level, bg_is_light
//   cfg_     in   register write, index 0..4, 8-bit data
//
// pass one pixel: taken straight from idle when unsampled; a sampled one adds a histogram read-modify-write state
// last pass one pixel: then walks the 256 bins, reading and clearing each, and reports the background
// pass two pixel: waits on the shared restoring divider, 8 steps for the saturation quotient
// after reset a clearing pass over the bins runs before the first pixel is taken
// a write to sample_stride rebuilds the stride phase (pixel index modulo stride) on the shared divider
// a full output register holds the block in its output state until taken
`default_nettype none
module chart_text_foreground_isolator #(
  parameter int COUNT_BITS = 24,
  parameter int HIST_BINS  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red, green, blue
  input  wire logic        in_tuser,   // req_type
  input  wire logic        in_tlast,   // last_pixel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // saturation, strength, chroma, background_level,
                                       // bg_is_light, zero pad
  output logic             out_tuser,  // kind
  output logic             out_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [ctfi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import ctfi_pkg::*;

  localparam int BIN_W = $clog2(HIST_BINS);
  localparam int WALK_W = BIN_W + 1;
  localparam int CUM_W = COUNT_BITS + BIN_W;
  localparam int STEP_W = $clog2(COUNT_BITS + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [BIN_W-1:0] LAST_BIN = {BIN_W{1'b1}};

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_MOD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [7:0] stride_r, mts_r, soft_r, strong_r, nsl_r;
  logic [COUNT_BITS-1:0] idx_r, idx_nxt, scount_r, scount_nxt, target_r, target_nxt;
  logic [7:0] phase_r, phase_nxt;
  logic [7:0] bg_r, bg_nxt;
  logic       light_r, light_nxt;
  logic       mod_req_r, mod_req_nxt;
  logic [WALK_W-1:0] walk_r, walk_nxt;
  logic       rv_r, rv_nxt;
  logic [BIN_W-1:0] prev_r, prev_nxt;
  logic [CUM_W-1:0] cum_r, cum_nxt;
  logic       found_r, found_nxt;
  logic [7:0] level_r, level_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [COUNT_BITS-1:0] sh_r, sh_nxt;
  logic [7:0] acc_r, acc_nxt, dvs_r, dvs_nxt, q_r, q_nxt;
  logic       req_r, last_r;
  logic [7:0] luma_r, cmax_r, delta_r;
  logic       out_valid_r;
  logic [39:0] out_data_r;
  logic       out_user_r, out_last_r;

  logic ram_we, ram_re;
  logic [BIN_W-1:0] ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  ctfi_ram #(.WIDTH(COUNT_BITS), .DEPTH(HIST_BINS)) u_hist (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [7:0] in_r, in_g, in_b, in_max, in_min, stride_eff;
  logic [15:0] luma_sum, sat_num;
  logic [7:0] in_luma;
  logic accept, out_free, walk_hit;
  logic [8:0] trial;
  logic [COUNT_BITS-1:0] bin_inc;
  logic [7:0] sat, contrast, strength;
  logic [10:0] c6;
  logic [9:0] c4, c3;
  logic [8:0] c2;
  logic neutral, moderate;

  assign in_r = in_tdata[7:0];
  assign in_g = in_tdata[15:8];
  assign in_b = in_tdata[23:16];
  assign luma_sum = 16'(16'd77 * in_r) + 16'(16'd150 * in_g) + 16'(16'd29 * in_b);
  assign in_luma = luma_sum[15:8];
  assign in_max = (in_r >= in_g) ? ((in_r >= in_b) ? in_r : in_b)
                                 : ((in_g >= in_b) ? in_g : in_b);
  assign in_min = (in_r <= in_g) ? ((in_r <= in_b) ? in_r : in_b)
                                 : ((in_g <= in_b) ? in_g : in_b);
  assign sat_num = {in_max - in_min, 8'd0} - {8'd0, in_max - in_min};
  assign stride_eff = (stride_r == 8'd0) ? 8'd1 : stride_r;

  assign in_tready = (state_r == S_IDLE) && !mod_req_r;
  assign accept = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign trial = {acc_r, sh_r[COUNT_BITS-1]};
  assign bin_inc = (ram_rdata == COUNT_MAX) ? COUNT_MAX : ram_rdata + 1'b1;
  assign cum_nxt = cum_r + CUM_W'(ram_rdata);
  assign walk_hit = cum_nxt >= CUM_W'(target_r);

  // pass two classification
  assign sat = (cmax_r == 8'd0) ? 8'd0 : q_r;
  assign contrast = light_r ? ((bg_r > luma_r) ? bg_r - luma_r : 8'd0)
                            : ((luma_r > bg_r) ? luma_r - bg_r : 8'd0);
  assign c6 = 11'(contrast) * 11'd6;
  assign c4 = {contrast, 2'b00};
  assign c3 = 10'(contrast) * 10'd3;
  assign c2 = {contrast, 1'b0};
  assign neutral = sat <= nsl_r;
  assign moderate = sat <= mts_r;

  always_comb begin
    strength = 8'd0;
    if (contrast >= strong_r && neutral) begin
      strength = (c6 > 11'd255) ? 8'd255 : c6[7:0];
    end else if (contrast >= soft_r && neutral) begin
      strength = (c4 > 10'd255) ? 8'd255 : c4[7:0];
    end else if (contrast >= strong_r && moderate) begin
      strength = (c3 > 10'd255) ? 8'd255 : c3[7:0];
    end
    if (strength == 8'd0 && contrast >= soft_r && moderate) begin
      strength = (c2 > 9'(MODERATE_CAP)) ? MODERATE_CAP : c2[7:0];
    end
    if (strength == 8'd0 && contrast >= MIN_CONTRAST &&
        (light_r ? (luma_r <= TEXT_DARK_MAX) : (luma_r >= TEXT_BRIGHT_MIN))) begin
      strength = (c2 > 9'd255) ? 8'd255 : c2[7:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    scount_nxt = scount_r;
    target_nxt = target_r;
    phase_nxt = phase_r;
    bg_nxt = bg_r;
    light_nxt = light_r;
    mod_req_nxt = mod_req_r;
    walk_nxt = walk_r;
    rv_nxt = 1'b0;
    prev_nxt = prev_r;
    found_nxt = found_r;
    level_nxt = level_r;
    step_nxt = step_r;
    sh_nxt = sh_r;
    acc_nxt = acc_r;
    dvs_nxt = dvs_r;
    q_nxt = q_r;
    ram_we = 1'b0;
    ram_waddr = prev_r;
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = in_luma;
    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        ram_waddr = walk_r[BIN_W-1:0];
        walk_nxt = walk_r + 1'b1;
        if (walk_r[BIN_W-1:0] == LAST_BIN) begin
          walk_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (mod_req_r) begin
          mod_req_nxt = 1'b0;
          sh_nxt = idx_r;
          acc_nxt = '0;
          dvs_nxt = stride_eff;
          step_nxt = STEP_W'(COUNT_BITS - 1);
          state_nxt = S_MOD;
        end else if (accept && !in_tuser) begin
          if (phase_r == 8'd0) begin
            ram_re = 1'b1;
            scount_nxt = (scount_r == COUNT_MAX) ? COUNT_MAX : scount_r + 1'b1;
            state_nxt = S_RMW;
          end
          if (idx_r != COUNT_MAX) begin
            idx_nxt = idx_r + 1'b1;
            phase_nxt = (9'(phase_r) + 9'd1 == 9'(stride_eff)) ? 8'd0 : phase_r + 8'd1;
          end
          if (in_tlast) begin
            target_nxt = scount_nxt >> 1;
            idx_nxt = '0;
            phase_nxt = '0;
            scount_nxt = '0;
            walk_nxt = '0;
            found_nxt = 1'b0;
            if (phase_r != 8'd0) begin
              state_nxt = S_WALK;
            end
          end
        end else if (accept) begin
          sh_nxt = {sat_num[7:0], {(COUNT_BITS-8){1'b0}}};
          acc_nxt = sat_num[15:8];
          dvs_nxt = in_max;
          q_nxt = '0;
          step_nxt = STEP_W'(DIV_STEPS);
          state_nxt = S_DIV;
        end
      end
      S_RMW: begin
        ram_we = 1'b1;
        ram_waddr = luma_r;
        ram_wdata = bin_inc;
        state_nxt = last_r ? S_WALK : S_IDLE;
      end
      S_WALK: begin
        ram_re = !walk_r[BIN_W];
        ram_raddr = walk_r[BIN_W-1:0];
        rv_nxt = !walk_r[BIN_W];
        prev_nxt = walk_r[BIN_W-1:0];
        walk_nxt = walk_r + 1'b1;
        if (rv_r) begin
          ram_we = 1'b1;
          if (!found_r && walk_hit) begin
            found_nxt = 1'b1;
            level_nxt = 8'(prev_r);
          end
          if (prev_r == LAST_BIN) begin
            bg_nxt = found_r ? level_r : (walk_hit ? 8'(prev_r) : LEVEL_MAX);
            light_nxt = bg_nxt >= MID_LEVEL;
            walk_nxt = '0;
            rv_nxt = 1'b0;
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV, S_MOD: begin
        sh_nxt = sh_r << 1;
        if (trial >= {1'b0, dvs_r}) begin
          acc_nxt = 8'(trial - {1'b0, dvs_r});
          q_nxt = {q_r[6:0], 1'b1};
        end else begin
          acc_nxt = trial[7:0];
          q_nxt = {q_r[6:0], 1'b0};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          if (state_r == S_MOD) begin
            phase_nxt = acc_nxt;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we && cfg_index == CFG_SAMPLE_STRIDE) begin
      mod_req_nxt = 1'b1;
    end
  end

  // cumulative count restarts on every walk
  logic cum_clr;
  assign cum_clr = accept && !in_tuser && in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      stride_r <= 8'd16;
      mts_r <= 8'd96;
      soft_r <= 8'd8;
      strong_r <= 8'd18;
      nsl_r <= 8'd48;
      idx_r <= '0;
      scount_r <= '0;
      phase_r <= '0;
      bg_r <= BG_RESET;
      light_r <= 1'b1;
      mod_req_r <= 1'b0;
      walk_r <= '0;
      rv_r <= 1'b0;
      found_r <= 1'b0;
      step_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      scount_r <= scount_nxt;
      phase_r <= phase_nxt;
      bg_r <= bg_nxt;
      light_r <= light_nxt;
      mod_req_r <= mod_req_nxt;
      walk_r <= walk_nxt;
      rv_r <= rv_nxt;
      found_r <= found_nxt;
      step_r <= step_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_STRIDE:   stride_r <= cfg_wdata;
          CFG_MAX_TEXT_SAT:    mts_r <= cfg_wdata;
          CFG_SOFT_CONTRAST:   soft_r <= cfg_wdata;
          CFG_STRONG_CONTRAST: strong_r <= cfg_wdata;
          CFG_NEUTRAL_SAT:     nsl_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    target_r <= target_nxt;
    prev_r <= prev_nxt;
    level_r <= level_nxt;
    sh_r <= sh_nxt;
    acc_r <= acc_nxt;
    dvs_r <= dvs_nxt;
    q_r <= q_nxt;
    if (cum_clr) begin
      cum_r <= '0;
    end else if (state_r == S_WALK && rv_r) begin
      cum_r <= cum_nxt;
    end
    if (accept) begin
      req_r <= in_tuser;
      last_r <= in_tlast;
      luma_r <= in_luma;
      cmax_r <= in_max;
      delta_r <= in_max - in_min;
    end
    if (state_r == S_OUT && out_free) begin
      out_user_r <= !req_r;
      out_last_r <= req_r ? last_r : 1'b1;
      out_data_r <= req_r ? {7'd0, light_r, bg_r, delta_r, strength, sat}
                          : {7'd0, light_r, bg_r, 24'd0};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
  assign out_tlast = out_last_r;

  a_report_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata[23:0] == 24'd0)
    else $error("background report carries pixel channels");
  a_walk_ports: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK && ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("walk clears the bin it reads");
  a_walk_counters: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> idx_r == '0 && scount_r == '0 && phase_r == 8'd0)
    else $error("pass counters not cleared during walk");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready)
    else $error("input taken while busy");
endmodule
`default_nettype wire

// ----- src/ctfi_ram.sv -----
// ctfi_ram: generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module ctfi_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire
